>>> rtl/kvs_pkg.sv
// kvs_pkg: shared constants, codes and types of the keyframe vec3 sampler.
// No dependencies; imported by every module of the block but kvs_ram.
package kvs_pkg;

	localparam int MAX_KEYS  = 64;
	localparam int KEY_AW    = $clog2(MAX_KEYS);
	localparam int CNT_W     = KEY_AW + 1;
	localparam int FRAC_BITS = 16;
	localparam int DATA_W    = 32;
	localparam int ALPHA_W   = FRAC_BITS + 1;
	localparam int H_W       = FRAC_BITS + 4;
	localparam int COEF_W    = 38;
	localparam int OPND_W    = DATA_W + 1;
	localparam int PROD_W    = COEF_W + OPND_W;
	localparam int ACC_W     = PROD_W + 3;
	localparam int LANES     = 3;
	localparam int LANE_RAM_W = 3 * DATA_W;
	localparam int DIV_CNT_W = $clog2(FRAC_BITS);
	localparam logic [ALPHA_W-1:0] ONE = ALPHA_W'(1) << FRAC_BITS;

	// stream payload layout
	localparam int IN_TDATA_W  = 328;
	localparam int OUT_TDATA_W = 104;
	localparam int OFS_INDEX = 0;
	localparam int OFS_TIME  = 6;
	localparam int OFS_VAL   = 38;
	localparam int OFS_IN    = 134;
	localparam int OFS_OUT   = 230;

	// config port
	localparam int APB_AW = 3;
	localparam logic REG_INTERP_MODE = 1'b0;
	localparam logic REG_KEY_COUNT   = 1'b1;

	localparam logic MODE_LOAD   = 1'b0;
	localparam logic MODE_SAMPLE = 1'b1;

	localparam logic [1:0] INTERP_STEP   = 2'd0;
	localparam logic [1:0] INTERP_LINEAR = 2'd1;
	localparam logic [1:0] INTERP_HERM   = 2'd2;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CHK_FIRST,
		ST_CHK_LAST,
		ST_SEARCH,
		ST_FETCH0,
		ST_FETCH1,
		ST_FETCH2,
		ST_DIV,
		ST_A2,
		ST_A3,
		ST_HCOEF,
		ST_HDT,
		ST_MAC,
		ST_MAC_WAIT,
		ST_OUT
	} state_t;

	typedef enum logic [1:0] {
		KIND_STEP,
		KIND_LIN,
		KIND_HERM
	} kind_t;

	typedef enum logic [2:0] {
		SEL_V0,
		SEL_O0,
		SEL_V1,
		SEL_I1,
		SEL_DIFF
	} sel_t;

	typedef struct packed {
		logic                     we;
		logic [KEY_AW-1:0]        waddr;
		logic                     re;
		logic [KEY_AW-1:0]        raddr;
		logic                     cap0;
		logic                     cap1;
		logic                     clr;
		logic                     mac_en;
		sel_t                     sel;
		logic signed [COEF_W-1:0] coef;
	} lane_ctrl_t;

endpackage

>>> rtl/keyframe_vec3_sampler.sv
// keyframe_vec3_sampler: top level, sequencer, key time store, weight math, output register.
// Depends on kvs_pkg, kvs_ram, kvs_div and kvs_lane.
//
//  port group | dir | payload, low bit first
//  -----------+-----+---------------------------------------------------------------
//  s_*        | in  | tuser: mode; tdata: key_index, key_time, value_x/y/z,
//             |     |   in_tan_x/y/z, out_tan_x/y/z, 2 zero pad bits
//  m_*        | out | tuser: was_empty, saturated; tdata: res_x/y/z, bracket, 2 pad
//  APB        | cfg | 0x0 interp_mode, 0x4 key_count
//
// One item at a time. A load beat writes all stores in its accept cycle and its
// result goes via ST_OUT to the output register. A sample beat runs bound checks
// on first and last key, a binary search, key fetch (ST_FETCH0 to ST_FETCH2),
// the 16-step weight divider, the Hermite weights (ST_A2 to ST_HDT) and up to
// four multiply-accumulate terms per lane. Step and linear skip what they do
// not need. No clearing pass after reset; the key stores hold garbage until
// loaded. The next beat is taken while the previous result waits on m_tready.
module keyframe_vec3_sampler (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [kvs_pkg::IN_TDATA_W-1:0]      s_tdata,   // see table above
	input  logic                                s_tuser,   // mode
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [kvs_pkg::OUT_TDATA_W-1:0]     m_tdata,   // res_x, res_y, res_z, bracket
	output logic [1:0]                          m_tuser,   // was_empty, saturated
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [kvs_pkg::APB_AW-1:0]          paddr,
	input  logic [31:0]                         pwdata,
	output logic [31:0]                         prdata,
	output logic                                pready
);
	import kvs_pkg::*;

	// ---------------- config registers
	logic [1:0]       interp_mode_q;
	logic [CNT_W-1:0] key_count_q;
	logic             cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			interp_mode_q <= INTERP_LINEAR;
			key_count_q   <= '0;
		end else if (cfg_wr) begin
			case (paddr[APB_AW-1])
				REG_INTERP_MODE: interp_mode_q <= pwdata[1:0];
				REG_KEY_COUNT:   key_count_q   <= pwdata[CNT_W-1:0];
				default: ;
			endcase
		end
	end

	assign prdata = (paddr[APB_AW-1] == REG_KEY_COUNT) ? 32'(key_count_q)
							   : 32'(interp_mode_q);

	// ---------------- input fields
	logic [KEY_AW-1:0] in_index;
	logic [DATA_W-1:0] in_time;
	logic              accept;
	logic              load_wr;
	logic [CNT_W-1:0]  n_in;

	assign in_index = s_tdata[OFS_INDEX +: KEY_AW];
	assign in_time  = s_tdata[OFS_TIME +: DATA_W];
	assign accept   = s_tvalid && s_tready;
	assign load_wr  = accept && (s_tuser == MODE_LOAD);
	// counts above capacity act as a full table
	assign n_in     = (key_count_q > CNT_W'(MAX_KEYS)) ? CNT_W'(MAX_KEYS) : key_count_q;

	// ---------------- state
	state_t state_q, state_d;

	logic [DATA_W-1:0]        q_q;
	logic [CNT_W-1:0]         n_q;
	logic [CNT_W-1:0]         lo_q, cnt_q;
	logic [KEY_AW-1:0]        idx_q;
	logic [DATA_W-1:0]        t0_q, dt_q;
	kind_t                    kind_q, kind_n;
	logic [ALPHA_W-1:0]       a_q, a2_q, a3_q;
	logic signed [H_W-1:0]    h00_q, h10_q, h01_q, h11_q;
	logic signed [COEF_W-1:0] hd10_q, hd11_q;
	logic [1:0]               term_q;
	logic                     zero_q, empty_q;

	// time store
	logic              t_re;
	logic [KEY_AW-1:0] t_raddr;
	logic [DATA_W-1:0] t_rdata;

	kvs_ram #(.WIDTH(DATA_W), .DEPTH(MAX_KEYS)) u_times (
		.clk   (clk),
		.we    (load_wr),
		.waddr (in_index),
		.wdata (in_time),
		.re    (t_re),
		.raddr (t_raddr),
		.rdata (t_rdata)
	);

	// ---------------- binary search step (compare on the probe read last cycle)
	logic [CNT_W-1:0] nm1, half, lo_n, cnt_n, probe_n, idx1;
	logic [CNT_W-1:0] idx_n;
	logic             ge;

	assign nm1     = n_q - 1'b1;
	assign half    = cnt_q >> 1;
	assign ge      = !(q_q < t_rdata);
	assign lo_n    = ge ? lo_q + half + 1'b1 : lo_q;
	assign cnt_n   = ge ? cnt_q - half - 1'b1 : half;
	assign probe_n = lo_n + (cnt_n >> 1);
	assign idx1    = CNT_W'(idx_q) + 1'b1;

	always_comb begin
		if (lo_n == '0) begin
			idx_n = '0;
		end else if (lo_n > nm1) begin
			idx_n = nm1;
		end else begin
			idx_n = lo_n - 1'b1;
		end
	end

	always_comb begin
		if (interp_mode_q == INTERP_STEP || idx1 >= n_q) begin
			kind_n = KIND_STEP;
		end else if (interp_mode_q == INTERP_HERM) begin
			kind_n = KIND_HERM;
		end else begin
			kind_n = KIND_LIN;
		end
	end

	// ---------------- weight: alpha = (q - t0) / (t1 - t0) in Q.16, clamped
	logic [DATA_W-1:0] diff_c, dt_c;
	logic              t_gt, q_gt, diff_ge;
	logic              div_start, div_done;
	logic [FRAC_BITS-1:0] div_quo;

	assign diff_c  = q_q - t0_q;
	assign dt_c    = t_rdata - t0_q;
	assign t_gt    = t_rdata > t0_q;
	assign q_gt    = q_q > t0_q;
	assign diff_ge = diff_c >= dt_c;

	kvs_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (diff_c),
		.den    (dt_c),
		.done   (div_done),
		.quo    (div_quo)
	);

	// Hermite basis: a squared, a cubed, the basis weights, then h10 and h11 scaled by dt
	logic [2*ALPHA_W-1:0]     a2_p, a3_p;
	logic signed [H_W-1:0]    sa, sa2, sa3;
	logic signed [H_W+DATA_W:0] p10, p11;

	assign a2_p = a_q * a_q;
	assign a3_p = a2_q * a_q;
	assign sa   = $signed(H_W'(a_q));
	assign sa2  = $signed(H_W'(a2_q));
	assign sa3  = $signed(H_W'(a3_q));
	assign p10  = h10_q * $signed({1'b0, dt_q});
	assign p11  = h11_q * $signed({1'b0, dt_q});

	// ---------------- MAC term select, shared by the three lanes
	sel_t                     term_sel;
	logic signed [COEF_W-1:0] term_coef;
	logic                     term_last;

	always_comb begin
		term_sel  = SEL_V0;
		term_coef = COEF_W'(ONE);
		term_last = 1'b1;
		case (kind_q)
			KIND_LIN: begin
				term_last = (term_q == 2'd1);
				if (term_q != 2'd0) begin
					term_sel  = SEL_DIFF;
					term_coef = COEF_W'(a_q);
				end
			end
			KIND_HERM: begin
				term_last = (term_q == 2'd3);
				case (term_q)
					2'd0: begin term_sel = SEL_V0; term_coef = COEF_W'(h00_q); end
					2'd1: begin term_sel = SEL_O0; term_coef = hd10_q; end
					2'd2: begin term_sel = SEL_V1; term_coef = COEF_W'(h01_q); end
					default: begin term_sel = SEL_I1; term_coef = hd11_q; end
				endcase
			end
			default: ;
		endcase
	end

	// ---------------- sequencer
	lane_ctrl_t lc;
	logic       out_free;

	assign out_free = !m_tvalid || m_tready;
	assign s_tready = (state_q == ST_IDLE);

	always_comb begin
		state_d   = state_q;
		t_re      = 1'b0;
		t_raddr   = '0;
		div_start = 1'b0;
		lc        = '0;
		lc.we     = load_wr;
		lc.waddr  = in_index;
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					if (s_tuser == MODE_LOAD || n_in == '0) begin
						state_d = ST_OUT;
					end else begin
						t_re    = 1'b1;
						state_d = ST_CHK_FIRST;
					end
				end
			end
			ST_CHK_FIRST: begin
				if (q_q <= t_rdata) begin
					state_d = ST_FETCH0;
				end else begin
					t_re    = 1'b1;
					t_raddr = nm1[KEY_AW-1:0];
					state_d = ST_CHK_LAST;
				end
			end
			ST_CHK_LAST: begin
				if (q_q >= t_rdata) begin
					state_d = ST_FETCH0;
				end else begin
					t_re    = 1'b1;
					t_raddr = KEY_AW'(n_q >> 1);
					state_d = ST_SEARCH;
				end
			end
			ST_SEARCH: begin
				if (cnt_n != '0) begin
					t_re    = 1'b1;
					t_raddr = probe_n[KEY_AW-1:0];
				end else begin
					state_d = ST_FETCH0;
				end
			end
			ST_FETCH0: begin
				t_re     = 1'b1;
				t_raddr  = idx_q;
				lc.re    = 1'b1;
				lc.raddr = idx_q;
				lc.clr   = 1'b1;
				state_d  = ST_FETCH1;
			end
			ST_FETCH1: begin
				lc.cap0 = 1'b1;
				if (kind_n == KIND_STEP) begin
					state_d = ST_MAC;
				end else begin
					t_re     = 1'b1;
					t_raddr  = idx1[KEY_AW-1:0];
					lc.re    = 1'b1;
					lc.raddr = idx1[KEY_AW-1:0];
					state_d  = ST_FETCH2;
				end
			end
			ST_FETCH2: begin
				lc.cap1 = 1'b1;
				if (t_gt && q_gt && !diff_ge) begin
					div_start = 1'b1;
					state_d   = ST_DIV;
				end else begin
					state_d = (kind_q == KIND_HERM) ? ST_A2 : ST_MAC;
				end
			end
			ST_DIV: begin
				if (div_done) begin
					state_d = (kind_q == KIND_HERM) ? ST_A2 : ST_MAC;
				end
			end
			ST_A2:    state_d = ST_A3;
			ST_A3:    state_d = ST_HCOEF;
			ST_HCOEF: state_d = ST_HDT;
			ST_HDT:   state_d = ST_MAC;
			ST_MAC: begin
				lc.mac_en = 1'b1;
				lc.sel    = term_sel;
				lc.coef   = term_coef;
				if (term_last) begin
					state_d = ST_MAC_WAIT;
				end
			end
			ST_MAC_WAIT: state_d = ST_OUT;
			ST_OUT: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// datapath registers, no reset needed
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				q_q     <= in_time;
				n_q     <= n_in;
				zero_q  <= (s_tuser == MODE_LOAD) || (n_in == '0);
				empty_q <= (s_tuser == MODE_SAMPLE) && (n_in == '0);
				idx_q   <= '0;
			end
			ST_CHK_FIRST: idx_q <= '0;
			ST_CHK_LAST: begin
				idx_q <= nm1[KEY_AW-1:0];
				lo_q  <= '0;
				cnt_q <= n_q;
			end
			ST_SEARCH: begin
				lo_q  <= lo_n;
				cnt_q <= cnt_n;
				if (cnt_n == '0) begin
					idx_q <= idx_n[KEY_AW-1:0];
				end
			end
			ST_FETCH0: term_q <= '0;
			ST_FETCH1: begin
				t0_q   <= t_rdata;
				kind_q <= kind_n;
			end
			ST_FETCH2: begin
				dt_q <= t_gt ? dt_c : '0;
				a_q  <= (t_gt && q_gt && diff_ge) ? ONE : '0;
			end
			ST_DIV: begin
				if (div_done) begin
					a_q <= ALPHA_W'(div_quo);
				end
			end
			ST_A2: a2_q <= a2_p[FRAC_BITS +: ALPHA_W];
			ST_A3: a3_q <= a3_p[FRAC_BITS +: ALPHA_W];
			ST_HCOEF: begin
				h00_q <= (sa3 <<< 1) - (sa2 + (sa2 <<< 1)) + $signed(H_W'(ONE));
				h10_q <= sa3 - (sa2 <<< 1) + sa;
				h01_q <= (sa2 + (sa2 <<< 1)) - (sa3 <<< 1);
				h11_q <= sa3 - sa2;
			end
			ST_HDT: begin
				hd10_q <= COEF_W'(p10 >>> FRAC_BITS);
				hd11_q <= COEF_W'(p11 >>> FRAC_BITS);
			end
			ST_MAC: term_q <= term_q + 1'b1;
			default: ;
		endcase
	end

	// ---------------- lanes x, y, z
	logic [DATA_W-1:0] lane_res  [LANES];
	logic [LANES-1:0]  lane_clip;

	for (genvar l = 0; l < LANES; l++) begin : g_lane
		kvs_lane u_lane (
			.clk    (clk),
			.arst_n (arst_n),
			.ctrl   (lc),
			.wdata  ({s_tdata[OFS_OUT + DATA_W*l +: DATA_W],
				  s_tdata[OFS_IN  + DATA_W*l +: DATA_W],
				  s_tdata[OFS_VAL + DATA_W*l +: DATA_W]}),
			.res    (lane_res[l]),
			.clip   (lane_clip[l])
		);
	end

	// ---------------- output register, merges the lanes
	logic                   m_tvalid_q;
	logic [OUT_TDATA_W-1:0] m_tdata_q;
	logic [1:0]             m_tuser_q;
	logic                   out_load;

	assign out_load = (state_q == ST_OUT) && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (out_load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			if (zero_q) begin
				m_tdata_q <= '0;
				m_tuser_q <= {1'b0, empty_q};
			end else begin
				m_tdata_q <= {2'b00, idx_q, lane_res[2], lane_res[1], lane_res[0]};
				m_tuser_q <= {|lane_clip, 1'b0};
			end
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

endmodule

>>> rtl/kvs_ram.sv
// kvs_ram: generic single write port, single read port RAM, registered read.
// No dependencies.
module kvs_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

>>> rtl/kvs_div.sv
// kvs_div: restoring divider for the interpolation weight, one quotient bit a cycle.
// Depends on kvs_pkg. Expects num < den, so the quotient fits FRAC_BITS bits.
module kvs_div (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  logic [kvs_pkg::DATA_W-1:0]      num,
	input  logic [kvs_pkg::DATA_W-1:0]      den,
	output logic                            done,
	output logic [kvs_pkg::FRAC_BITS-1:0]   quo
);
	import kvs_pkg::*;

	logic                 busy_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [DATA_W-1:0]    rem_q;
	logic [DATA_W-1:0]    den_q;
	logic [FRAC_BITS-1:0] quo_q;
	logic [DATA_W:0]      rem_sh;
	logic                 fits;

	assign rem_sh = {rem_q, 1'b0};
	assign fits   = rem_sh >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
			end else if (busy_q && cnt_q == '0) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= num;
			den_q <= den;
			cnt_q <= DIV_CNT_W'(FRAC_BITS - 1);
		end else if (busy_q) begin
			rem_q <= fits ? DATA_W'(rem_sh - {1'b0, den_q}) : rem_sh[DATA_W-1:0];
			quo_q <= {quo_q[FRAC_BITS-2:0], fits};
			cnt_q <= cnt_q - 1'b1;
		end
	end

	assign done = done_q;
	assign quo  = quo_q;

endmodule

>>> rtl/kvs_lane.sv
// kvs_lane: one vector component: key store, operand hold, multiply-accumulate, saturate.
// Depends on kvs_pkg and kvs_ram.
module kvs_lane (
	input  logic                                clk,
	input  logic                                arst_n,
	input  kvs_pkg::lane_ctrl_t                 ctrl,
	input  logic [kvs_pkg::LANE_RAM_W-1:0]      wdata,   // {out_tan, in_tan, value}
	output logic [kvs_pkg::DATA_W-1:0]          res,
	output logic                                clip
);
	import kvs_pkg::*;

	localparam int SHR_W = ACC_W - FRAC_BITS;

	logic [LANE_RAM_W-1:0]      rdata;
	logic signed [DATA_W-1:0]   v0_q, o0_q, v1_q, i1_q;
	logic signed [OPND_W-1:0]   opnd;
	logic signed [PROD_W-1:0]   prod_s1;
	logic                       mac_v_s1;
	logic signed [ACC_W-1:0]    acc_q;
	logic signed [SHR_W-1:0]    shr;
	logic signed [SHR_W-1:0]    lim_hi, lim_lo;

	kvs_ram #(.WIDTH(LANE_RAM_W), .DEPTH(MAX_KEYS)) u_ram (
		.clk   (clk),
		.we    (ctrl.we),
		.waddr (ctrl.waddr),
		.wdata (wdata),
		.re    (ctrl.re),
		.raddr (ctrl.raddr),
		.rdata (rdata)
	);

	always_ff @(posedge clk) begin
		if (ctrl.cap0) begin
			v0_q <= rdata[DATA_W-1:0];
			o0_q <= rdata[3*DATA_W-1:2*DATA_W];
		end
		if (ctrl.cap1) begin
			v1_q <= rdata[DATA_W-1:0];
			i1_q <= rdata[2*DATA_W-1:DATA_W];
		end
	end

	always_comb begin
		case (ctrl.sel)
			SEL_V0:   opnd = OPND_W'(v0_q);
			SEL_O0:   opnd = OPND_W'(o0_q);
			SEL_V1:   opnd = OPND_W'(v1_q);
			SEL_I1:   opnd = OPND_W'(i1_q);
			SEL_DIFF: opnd = OPND_W'(v1_q) - OPND_W'(v0_q);
			default:  opnd = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		prod_s1 <= ctrl.coef * opnd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mac_v_s1 <= 1'b0;
		end else begin
			mac_v_s1 <= ctrl.mac_en;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.clr) begin
			acc_q <= '0;
		end else if (mac_v_s1) begin
			acc_q <= acc_q + ACC_W'(prod_s1);
		end
	end

	// floor shift back to Q16.16, then clip to 32 bits
	assign shr    = acc_q[ACC_W-1:FRAC_BITS];
	assign lim_hi = SHR_W'({1'b0, {(DATA_W-1){1'b1}}});
	assign lim_lo = -lim_hi - SHR_W'(1);

	always_comb begin
		clip = 1'b1;
		if (shr > lim_hi) begin
			res = lim_hi[DATA_W-1:0];
		end else if (shr < lim_lo) begin
			res = lim_lo[DATA_W-1:0];
		end else begin
			res  = shr[DATA_W-1:0];
			clip = 1'b0;
		end
	end

endmodule

>>> rtl/kvs_chk.sv
// kvs_chk: port-level checks on the keyframe vec3 sampler, bound to the top level.
// Depends on kvs_pkg for widths.
module kvs_chk (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            s_tvalid,
	input logic                            s_tready,
	input logic                            m_tvalid,
	input logic                            m_tready,
	input logic [kvs_pkg::OUT_TDATA_W-1:0] m_tdata,
	input logic [1:0]                      m_tuser
);
	import kvs_pkg::*;

	// one item in flight: an accepted beat closes the input for the next cycle
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input taken twice in a row");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("stalled result changed");

	// empty table gives zero vector, bracket zero and no clip
	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> m_tdata == '0 && !m_tuser[1])
		else $error("empty result not zero");

endmodule

bind keyframe_vec3_sampler kvs_chk u_kvs_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

>>> dv/tb_keyframe_vec3_sampler.sv
// tb_keyframe_vec3_sampler: self-checking bench for the keyframe vec3 sampler.
// Depends on kvs_pkg and the keyframe_vec3_sampler RTL; nothing else.
// Loads key tables, samples them under each interpolation mode, checks every result beat.
module tb_keyframe_vec3_sampler;
	import kvs_pkg::*;

	localparam int LIMIT = 2_000_000;

	typedef struct {
		logic              mode;
		logic [5:0]        idx;
		logic [31:0]       ktime;
		logic [31:0]       val [3];
		logic [31:0]       tin [3];
		logic [31:0]       tout [3];
	} key_beat_t;

	typedef struct {
		logic [31:0] res [3];
		logic [5:0]  bracket;
		logic        empty;
		logic        sat;
	} sample_t;

	logic clk = 0;
	logic arst_n = 0;
	logic s_tvalid = 0;
	logic s_tready;
	logic [IN_TDATA_W-1:0] s_tdata = '0;   // key_index, key_time, value_x/y/z, in_tan, out_tan, pad
	logic s_tuser = 0;                      // mode
	logic m_tvalid;
	logic m_tready = 0;
	logic [OUT_TDATA_W-1:0] m_tdata;       // res_x, res_y, res_z, bracket, pad
	logic [1:0] m_tuser;                   // was_empty, saturated
	logic psel = 0, penable = 0, pwrite = 0;
	logic [APB_AW-1:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	keyframe_vec3_sampler i_dut (.*);

	always #5 clk = ~clk;

	// shadow of the block: key store and registers
	logic [31:0] key_t [MAX_KEYS];
	logic [31:0] key_v [MAX_KEYS][3];
	logic [31:0] key_i [MAX_KEYS][3];
	logic [31:0] key_o [MAX_KEYS][3];
	logic [1:0]  cur_interp = INTERP_LINEAR;
	logic [6:0]  cur_count = 0;

	// times as seen by the stimulus generator (ahead of acceptance)
	logic [31:0] plan_t [MAX_KEYS];

	key_beat_t pend_beats[$];
	sample_t   expected_samples[$];
	key_beat_t cur_beat;
	int errors = 0;
	int cycles = 0;
	int burst_left = 0, gap_left = 0;
	int stall_kind = 0;

	function automatic longint sx(logic [31:0] v);
		return longint'($signed(v));
	endfunction

	function automatic logic [31:0] clip32(longint x, inout logic c);
		if (x > 64'sd2147483647) begin
			c = 1;
			return 32'h7FFF_FFFF;
		end
		if (x < -64'sd2147483648) begin
			c = 1;
			return 32'h8000_0000;
		end
		return x[31:0];
	endfunction

	// lower key of the bracket: clamp to ends, else upper-bound search
	function automatic int lower_key(int n, logic [31:0] q);
		int lo, cnt, half;
		lo = 0;
		cnt = n;
		if (q <= key_t[0]) return 0;
		if (q >= key_t[n-1]) return n - 1;
		while (cnt > 0) begin
			half = cnt / 2;
			if (!(q < key_t[lo+half])) begin
				lo += half + 1;
				cnt -= half + 1;
			end else begin
				cnt = half;
			end
		end
		if (lo == 0) return 0;
		if (lo > n - 1) return n - 1;
		return lo - 1;
	endfunction

	function automatic sample_t sample_keys(logic [31:0] q);
		sample_t s;
		int n, i;
		longint r [3];
		longint t0, t1, a, dt, diff, a2, a3, h00, h10, h01, h11, hd10, hd11, one;
		logic c;
		one = 64'sd1 << FRAC_BITS;
		s.res = '{default: '0};
		s.bracket = '0;
		s.empty = 0;
		s.sat = 0;
		n = (cur_count > MAX_KEYS) ? MAX_KEYS : int'(cur_count);
		if (n == 0) begin
			s.empty = 1;
			return s;
		end
		i = lower_key(n, q);
		for (int k = 0; k < 3; k++) r[k] = sx(key_v[i][k]);
		if (cur_interp != INTERP_STEP && i + 1 < n) begin
			t0 = longint'(key_t[i]);
			t1 = longint'(key_t[i+1]);
			a = 0;
			// zero-length or reversed interval leaves alpha at zero
			if (t1 > t0) begin
				diff = longint'(q) - t0;
				if (diff > 0) begin
					a = (diff <<< FRAC_BITS) / (t1 - t0);
					if (a > one) a = one;
				end
			end
			if (cur_interp == INTERP_HERM) begin
				dt = (t1 > t0) ? t1 - t0 : 0;
				a2 = (a * a) >>> FRAC_BITS;
				a3 = (a2 * a) >>> FRAC_BITS;
				h00 = 2 * a3 - 3 * a2 + one;
				h10 = a3 - 2 * a2 + a;
				h01 = 3 * a2 - 2 * a3;
				h11 = a3 - a2;
				hd10 = (h10 * dt) >>> FRAC_BITS;
				hd11 = (h11 * dt) >>> FRAC_BITS;
				for (int k = 0; k < 3; k++)
					r[k] = (h00 * r[k] + hd10 * sx(key_o[i][k]) + h01 * sx(key_v[i+1][k])
						+ hd11 * sx(key_i[i+1][k])) >>> FRAC_BITS;
			end else begin
				// linear, and the unused mode 3
				for (int k = 0; k < 3; k++)
					r[k] = r[k] + (((sx(key_v[i+1][k]) - r[k]) * a) >>> FRAC_BITS);
			end
		end
		c = 0;
		for (int k = 0; k < 3; k++) s.res[k] = clip32(r[k], c);
		s.sat = c;
		s.bracket = i[5:0];
		return s;
	endfunction

	// accepted input beat: update store or predict a sample
	function automatic void take_beat(key_beat_t b);
		sample_t s;
		if (b.mode == MODE_LOAD) begin
			key_t[b.idx] = b.ktime;
			key_v[b.idx] = b.val;
			key_i[b.idx] = b.tin;
			key_o[b.idx] = b.tout;
			s.res = '{default: '0};
			s.bracket = '0;
			s.empty = 0;
			s.sat = 0;
		end else begin
			s = sample_keys(b.ktime);
		end
		expected_samples.push_back(s);
	endfunction

	// driver: bursts of beats separated by random gaps
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 0;
		end else begin
			if (s_tvalid && s_tready) take_beat(cur_beat);
			if (!s_tvalid || s_tready) begin
				if (gap_left > 0) begin
					gap_left--;
					s_tvalid <= 0;
				end else if (pend_beats.size() > 0) begin
					cur_beat = pend_beats.pop_front();
					s_tdata <= {2'b00, cur_beat.tout[2], cur_beat.tout[1], cur_beat.tout[0],
						cur_beat.tin[2], cur_beat.tin[1], cur_beat.tin[0],
						cur_beat.val[2], cur_beat.val[1], cur_beat.val[0],
						cur_beat.ktime, cur_beat.idx};
					s_tuser <= cur_beat.mode;
					s_tvalid <= 1;
					if (burst_left == 0) begin
						burst_left = $urandom_range(1, 12);
						// long gaps can land on any stage of a sample
						gap_left = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 60) : 0;
					end else begin
						burst_left--;
					end
				end else begin
					s_tvalid <= 0;
				end
			end
		end
	end

	task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
		if (exp_v !== act_v) begin
			$display("%0t %s mismatch: expected %h actual %h", $realtime, name, exp_v, act_v);
			errors++;
		end
	endtask

	// monitor: checks each result beat and varies the receiver stall pattern
	always @(posedge clk or negedge arst_n) begin
		sample_t e;
		if (!arst_n) begin
			m_tready <= 0;
		end else begin
			cycles++;
			if (cycles > LIMIT) begin
				$display("tb_keyframe_vec3_sampler: errors");
				$finish;
			end
			if (m_tvalid && m_tready) begin
				if (expected_samples.size() == 0) begin
					$display("%0t unexpected result beat: expected none actual %h", $realtime,
						m_tdata);
					errors++;
				end else begin
					e = expected_samples.pop_front();
					check_field("res_x", e.res[0], m_tdata[31:0]);
					check_field("res_y", e.res[1], m_tdata[63:32]);
					check_field("res_z", e.res[2], m_tdata[95:64]);
					check_field("bracket", 32'(e.bracket), 32'(m_tdata[101:96]));
					check_field("was_empty", 32'(e.empty), 32'(m_tuser[0]));
					check_field("saturated", 32'(e.sat), 32'(m_tuser[1]));
				end
			end
			if (cycles % 256 == 0) stall_kind = $urandom_range(0, 3);
			case (stall_kind)
				0: m_tready <= 1;
				1: m_tready <= 1'($urandom_range(0, 1));
				2: m_tready <= ($urandom_range(0, 7) == 0);
				default: m_tready <= ((cycles / 16) % 2 == 0);
			endcase
		end
	end

	// APB write: setup then access; register taken on the access edge
	task automatic reg_write(logic [APB_AW-1:0] addr, logic [31:0] data);
		@(posedge clk);
		psel <= 1;
		pwrite <= 1;
		penable <= 0;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		if (addr == 3'(4 * REG_INTERP_MODE)) cur_interp = data[1:0];
		else cur_count = data[6:0];
		psel <= 0;
		penable <= 0;
		pwrite <= 0;
	endtask

	task automatic wait_idle();
		do @(negedge clk);
		while (pend_beats.size() > 0 || s_tvalid || expected_samples.size() > 0);
		repeat (4) @(posedge clk);
	endtask

	function automatic logic [31:0] pick_value(int wild);
		case ($urandom_range(0, 7))
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			2: return wild ? $urandom : $urandom_range(0, 32'h0003_FFFF);
			default: return wild ? $urandom : 32'($signed($urandom_range(0, 32'h00FF_FFFF))
				- 32'sh0080_0000);
		endcase
	endfunction

	function automatic void push_load(logic [5:0] idx, logic [31:0] t, int wild);
		key_beat_t b;
		b.mode = MODE_LOAD;
		b.idx = idx;
		b.ktime = t;
		for (int k = 0; k < 3; k++) begin
			b.val[k] = pick_value(wild);
			b.tin[k] = pick_value(wild);
			b.tout[k] = pick_value(wild);
		end
		plan_t[idx] = t;
		pend_beats.push_back(b);
	endfunction

	function automatic void push_sample(logic [31:0] q);
		key_beat_t b;
		b.mode = MODE_SAMPLE;
		b.idx = 6'($urandom);
		b.ktime = q;
		for (int k = 0; k < 3; k++) begin
			b.val[k] = $urandom;
			b.tin[k] = $urandom;
			b.tout[k] = $urandom;
		end
		pend_beats.push_back(b);
	endfunction

	// whole table: sorted with random gaps, with repeated times, unsorted, or near the top of the time range
	function automatic void fill_table(int shape, int wild);
		logic [31:0] t, step_max;
		t = (shape == 3) ? 32'hFFFF_0000 - 32'($urandom_range(0, 64 * 1024))
			: $urandom_range(0, 32'h4000_0000);
		step_max = (shape == 3) ? 1024 : $urandom_range(1, 32'h0100_0000);
		for (int j = 0; j < MAX_KEYS; j++) begin
			if (shape == 2) t = $urandom;
			else if (!(shape == 1 && $urandom_range(0, 2) == 0)) t += $urandom_range(1, step_max);
			push_load(j[5:0], t, wild);
		end
	endfunction

	function automatic logic [31:0] pick_query(int n);
		int j;
		j = (n > 0) ? $urandom_range(0, ((n > MAX_KEYS) ? MAX_KEYS : n) - 1) : 0;
		case ($urandom_range(0, 9))
			0: return 32'h0;
			1: return 32'hFFFF_FFFF;
			2: return plan_t[j];
			3: return $urandom;
			4: return plan_t[j] - 32'($urandom_range(1, 1000));
			default: return plan_t[j] + $urandom_range(0, (j + 1 < MAX_KEYS) ?
				plan_t[j+1] - plan_t[j] : 1000);
		endcase
	endfunction

	initial begin
		int items;
		int dir_interp [8] = '{1, 0, 1, 2, 3, 2, 1, 2};
		int dir_count [8] = '{0, 64, 64, 64, 64, 1, 127, 2};
		int pi, pc, ns;
		repeat (8) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// empty table at reset count, then the first full table
		push_sample(32'h0);
		push_sample(32'hFFFF_FFFF);
		fill_table(0, 0);
		wait_idle();
		items = 66;

		for (int ph = 0; items < 1100; ph++) begin
			if (ph < 8) begin
				pi = dir_interp[ph];
				pc = dir_count[ph];
			end else begin
				pi = $urandom_range(0, 3);
				case ($urandom_range(0, 7))
					0: pc = 0;
					1: pc = $urandom_range(65, 127);
					2: pc = 64;
					3: pc = $urandom_range(1, 3);
					default: pc = $urandom_range(1, 64);
				endcase
				if ($urandom_range(0, 3) == 0) begin
					fill_table($urandom_range(0, 3), $urandom_range(0, 1));
					items += 64;
					// table loads drain before the registers change
					wait_idle();
				end
			end
			reg_write(3'(4 * REG_INTERP_MODE), 32'(pi));
			reg_write(3'(4 * REG_KEY_COUNT), 32'(pc));
			ns = (ph < 8) ? 3 : $urandom_range(20, 60);
			for (int j = 0; j < ns; j++) begin
				// a few stray rewrites mixed in with the samples
				if (ph >= 8 && $urandom_range(0, 9) == 0)
					push_load(6'($urandom), ($urandom_range(0, 1) == 0) ? $urandom
						: plan_t[$urandom_range(0, 63)] + 1, 1);
				push_sample(pick_query(pc));
				items++;
			end
			wait_idle();
		end

		wait_idle();
		repeat (50) @(posedge clk);
		if (errors == 0) begin
			$display("tb_keyframe_vec3_sampler: clean");
		end else begin
			$display("tb_keyframe_vec3_sampler: errors");
		end
		$finish;
	end

endmodule

>>> keyframe_vec3_sampler.f
rtl/kvs_pkg.sv
rtl/kvs_ram.sv
rtl/kvs_div.sv
rtl/kvs_lane.sv
rtl/keyframe_vec3_sampler.sv
rtl/kvs_chk.sv
dv/tb_keyframe_vec3_sampler.sv
